FILE: rtl/pls_pkg.sv
package pls_pkg;

    localparam int WORD_W    = 32;
    localparam int MODE_W    = 3;
    localparam int POS_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;
    localparam int DEPTH_DEF = 16;

    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic                     ins;
        logic                     ers;
        logic signed [WORD_W-1:0] val;
    } cell_cmd_t;

endpackage

FILE: rtl/pls_cell.sv
module pls_cell #(
    parameter int IDX_W = 5,
    parameter int IDX   = 0
) (
    input  logic                              clk,
    input  pls_pkg::cell_cmd_t                cmd,
    input  logic [IDX_W-1:0]                  idx,
    input  logic signed [pls_pkg::WORD_W-1:0] left_word,
    input  logic signed [pls_pkg::WORD_W-1:0] right_word,
    output logic signed [pls_pkg::WORD_W-1:0] word,
    output logic [pls_pkg::WORD_W-1:0]        sel_word
);
    import pls_pkg::*;

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;
    logic                     hit;
    logic                     after;

    assign hit   = (idx == IDX_W'(IDX));
    assign after = (idx < IDX_W'(IDX));

    always_comb
    begin
        word_next = word_reg;
        if (cmd.ins && hit)
        begin
            word_next = cmd.val;
        end
        else if (cmd.ins && after)
        begin
            word_next = left_word;
        end
        else if (cmd.ers && (hit || after))
        begin
            word_next = right_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word     = word_reg;
    assign sel_word = hit ? word_reg : '0;

endmodule

FILE: rtl/positional_list_store.sv
// Ordered list of up to DEPTH signed words held in a row of cells, slot 0 at the head.
// Every request (append, push, pop, insert, erase, read) gives exactly one result
// with the word popped or read, a status and the entry count afterwards; a failed
// request leaves the list unchanged. All cells compare their slot with the index and
// shift towards head or tail together, so the row accepts one request per clock
// while no result waits unaccepted, and the result sits in the output register from
// the next cycle. A new request is taken while the last result is being taken.
module positional_list_store #(
    parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pls_pkg::MODE_W-1:0]          mode,
    input  logic [pls_pkg::POS_W-1:0]           position,
    input  logic signed [pls_pkg::WORD_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pls_pkg::WORD_W-1:0]   read_data,
    output logic [pls_pkg::STATUS_W-1:0]        status,
    output logic [pls_pkg::COUNT_W-1:0]         entry_count
);
    import pls_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]             used_count_reg;
    logic [CW-1:0]             used_count_next;
    logic                      out_valid_reg;
    logic signed [WORD_W-1:0]  read_data_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic [COUNT_W-1:0]        entry_count_reg;

    logic                      in_accept;
    logic [IW-1:0]             pos_ext;
    logic [IW-1:0]             used_ext;
    logic                      full;
    logic                      empty;
    logic [STATUS_W-1:0]       st;
    logic                      do_ins;
    logic                      do_ers;
    logic                      do_rd;
    logic [IW-1:0]             idx;
    cell_cmd_t                 cmd;
    logic [WORD_W-1:0]         rd_bus;

    logic signed [WORD_W-1:0]  cell_word [DEPTH];
    logic [WORD_W-1:0]         cell_sel  [DEPTH];

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    assign pos_ext  = IW'(position);
    assign used_ext = IW'(used_count_reg);
    assign full     = (used_count_reg == CW'(DEPTH));
    assign empty    = (used_count_reg == '0);

    always_comb
    begin
        st              = ST_OK;
        do_ins          = 1'b0;
        do_ers          = 1'b0;
        do_rd           = 1'b0;
        idx             = pos_ext;
        used_count_next = used_count_reg;
        unique case (mode)
            MODE_APPEND:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    do_ins          = 1'b1;
                    idx             = used_ext;
                    used_count_next = used_count_reg + CW'(1);
                end
            end
            MODE_PUSH:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    do_ins          = 1'b1;
                    idx             = '0;
                    used_count_next = used_count_reg + CW'(1);
                end
            end
            MODE_POP:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    do_ers          = 1'b1;
                    do_rd           = 1'b1;
                    idx             = '0;
                    used_count_next = used_count_reg - CW'(1);
                end
            end
            MODE_INSERT:
            begin
                if (pos_ext > used_ext)
                begin
                    st = ST_RANGE;
                end
                else if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    do_ins          = 1'b1;
                    used_count_next = used_count_reg + CW'(1);
                end
            end
            MODE_ERASE:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else if (pos_ext >= used_ext)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    do_ers          = 1'b1;
                    used_count_next = used_count_reg - CW'(1);
                end
            end
            MODE_READ:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else if (pos_ext >= used_ext)
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    do_rd = 1'b1;
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    assign cmd.ins = do_ins && in_accept;
    assign cmd.ers = do_ers && in_accept;
    assign cmd.val = value;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        pls_cell #(
            .IDX_W (IW),
            .IDX   (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .idx        (idx),
            .left_word  ((i == 0) ? value : cell_word[(i == 0) ? 0 : i - 1]),
            .right_word ((i == DEPTH - 1) ? cell_word[i]
                                          : cell_word[(i == DEPTH - 1) ? i : i + 1]),
            .word       (cell_word[i]),
            .sel_word   (cell_sel[i])
        );
    end

    // only the addressed cell drives a non-zero word
    always_comb
    begin
        rd_bus = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_bus = rd_bus | cell_sel[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                used_count_reg <= used_count_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            read_data_reg   <= do_rd ? $signed(rd_bus) : '0;
            status_reg      <= st;
            entry_count_reg <= COUNT_W'(used_count_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> used_count_reg == $past(used_count_reg) + CW'(1))
        else $error("insert did not grow the list");

    a_erase_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ers |=> used_count_reg == $past(used_count_reg) - CW'(1))
        else $error("erase did not shrink the list");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |-> read_data_reg == '0)
        else $error("failed transaction carries read data");

endmodule
